[hdl/stok_pkg.sv]
// stok_pkg: shared types, character codes, token kinds and keyword tables
// for the source tokenizer. No dependencies.
package stok_pkg;

   localparam int MAX_SOURCE_BYTES_DEF = 65536;
   localparam int KEYWORD_MAX_LEN_DEF  = 6;
   localparam int KEYWORD_COUNT        = 8;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'd0,
      MODE_LINE   = 4'd1,
      MODE_BLOCK  = 4'd2,
      MODE_IDENT  = 4'd3,
      MODE_CONST  = 4'd4,
      MODE_STRING = 4'd5,
      MODE_CH1    = 4'd6,
      MODE_CH2    = 4'd7,
      MODE_OP     = 4'd8
   } mode_type;

   // token kinds
   localparam logic [5:0] KIND_END     = 6'd0;
   localparam logic [5:0] KIND_LPAREN  = 6'd1;
   localparam logic [5:0] KIND_RPAREN  = 6'd2;
   localparam logic [5:0] KIND_LBRACE  = 6'd3;
   localparam logic [5:0] KIND_RBRACE  = 6'd4;
   localparam logic [5:0] KIND_STAR    = 6'd5;
   localparam logic [5:0] KIND_SLASH   = 6'd6;
   localparam logic [5:0] KIND_PERCENT = 6'd7;
   localparam logic [5:0] KIND_COMMA   = 6'd8;
   localparam logic [5:0] KIND_SEMI    = 6'd9;
   localparam logic [5:0] KIND_INC     = 6'd10;
   localparam logic [5:0] KIND_PLUS    = 6'd11;
   localparam logic [5:0] KIND_DEC     = 6'd12;
   localparam logic [5:0] KIND_MINUS   = 6'd13;
   localparam logic [5:0] KIND_LE      = 6'd14;
   localparam logic [5:0] KIND_LT      = 6'd15;
   localparam logic [5:0] KIND_GE      = 6'd16;
   localparam logic [5:0] KIND_GT      = 6'd17;
   localparam logic [5:0] KIND_EQ      = 6'd18;
   localparam logic [5:0] KIND_ASSIGN  = 6'd19;
   localparam logic [5:0] KIND_NE      = 6'd20;
   localparam logic [5:0] KIND_NOT     = 6'd21;
   localparam logic [5:0] KIND_AND     = 6'd22;
   localparam logic [5:0] KIND_OR      = 6'd23;
   localparam logic [5:0] KIND_STRLIT  = 6'd24;
   localparam logic [5:0] KIND_CHARLIT = 6'd25;
   localparam logic [5:0] KIND_CONST   = 6'd26;
   localparam logic [5:0] KIND_IDENT   = 6'd35;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_COMMENT  = 3'd1;
   localparam logic [2:0] ERR_AMP      = 3'd2;
   localparam logic [2:0] ERR_BAR      = 3'd3;
   localparam logic [2:0] ERR_STRING   = 3'd4;
   localparam logic [2:0] ERR_CHARLIT  = 3'd5;
   localparam logic [2:0] ERR_BADCHAR  = 3'd6;

   // characters
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BAR    = 8'h7C;

   // keyword text, first byte in the low bits, unused bytes zero
   localparam logic [47:0] KW_TEXT [KEYWORD_COUNT] = '{
      48'h0000_7261_6863,   // char
      48'h0000_6573_6C65,   // else
      48'h0000_0072_6F66,   // for
      48'h0000_0070_6F68,   // hop
      48'h0000_0000_6669,   // if
      48'h0000_0074_6E69,   // int
      48'h676E_6972_7473,   // string
      48'h0065_6C69_6877    // while
   };
   localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{
      3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd3, 3'd6, 3'd5
   };
   localparam logic [5:0] KW_KIND [KEYWORD_COUNT] = '{
      6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34
   };

   typedef struct packed {
      logic       valid;
      logic [5:0] kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [2:0] err;
      logic       last;
   } rsp_type;

   // one-byte tokens that never wait for a following byte
   function automatic logic [5:0] char_kind(input logic [7:0] c);
      logic [5:0] k;
      k = KIND_END;
      case (c)
         8'h28: k = KIND_LPAREN;
         8'h29: k = KIND_RPAREN;
         8'h7B: k = KIND_LBRACE;
         8'h7D: k = KIND_RBRACE;
         8'h2A: k = KIND_STAR;
         8'h2F: k = KIND_SLASH;
         8'h25: k = KIND_PERCENT;
         8'h2C: k = KIND_COMMA;
         8'h3B: k = KIND_SEMI;
         8'h30: k = KIND_CONST;
         default: k = KIND_END;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] single_op_kind(input logic [7:0] p);
      logic [5:0] k;
      case (p)
         CH_PLUS:  k = KIND_PLUS;
         CH_MINUS: k = KIND_MINUS;
         CH_LT:    k = KIND_LT;
         CH_GT:    k = KIND_GT;
         CH_EQ:    k = KIND_ASSIGN;
         default:  k = KIND_NOT;
      endcase
      return k;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

endpackage

[hdl/source_tokenizer.sv]
// source_tokenizer: streaming lexer, one source byte per request.
// Depends on stok_pkg.
//
// Usage
//  - req_* carries one source byte per request in req_tdata[7:0]; a request
//    with req_tlast high is the end of source and its byte is ignored.
//  - rsp_* carries tokens: kind on rsp_tuser, offset/length/error code on
//    rsp_tdata, and rsp_tlast on the final token caused by a request.
//  - A request may cause zero, one or two tokens (a token ends when the
//    byte after it arrives, so that byte can close one token and start or
//    emit another). End of source flushes the pending token, then gives the
//    end token (or an error) and returns the block to its reset state.
//  - After an error, bytes give no tokens until end of source, which gives
//    nothing and restarts the block.
// Timing
//  - The state update and token build sit between the request handshake and
//    a two-entry result buffer: tokens appear in the cycle after the request.
//  - One request per cycle while each request yields at most one token and
//    the receiver keeps up; after a request yielding two tokens, the next
//    request waits while the single rsp port drains the two-entry buffer.
//  - When the receiver stalls, req_tready drops once a token is waiting.
// Reset: synchronous, active high; clears scanner state and the buffer.
module source_tokenizer
   import stok_pkg::*;
#(
   parameter int MAX_SOURCE_BYTES = MAX_SOURCE_BYTES_DEF,
   parameter int KEYWORD_MAX_LEN  = KEYWORD_MAX_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tlast,   // end_of_source
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] start_offset, [31:16] token_length,
                                    // [34:32] error_code, [39:35] zero
   output logic [5:0]  rsp_tuser,   // [5:0] token_kind
   output logic        rsp_tlast    // last_of_run
);

   localparam logic [15:0] OFFSET_CAP =
      (MAX_SOURCE_BYTES - 1 < 65535) ? 16'(MAX_SOURCE_BYTES - 1) : 16'hFFFF;

   // scanner state
   mode_type    mode_ff, mode_in;
   logic [15:0] off_ff, off_in;
   logic [15:0] tstart_ff, tstart_in;
   logic [7:0]  pend_ff, pend_in;
   logic [7:0]  kb_ff [KEYWORD_MAX_LEN];
   logic [7:0]  kb_in [KEYWORD_MAX_LEN];
   logic [15:0] len_ff, len_in;
   logic        dash_ff, dash_in;
   logic        halt_ff, halt_in;

   // result buffer, slot 0 is the head
   rsp_type     slot_ff [2];
   rsp_type     slot_in [2];
   logic [1:0]  cnt_ff, cnt_in;

   rsp_type     r0, r1, sfi_res, ident_res;
   logic        take_sfi;
   logic [7:0]  c;
   logic [5:0]  kw_kind, sk;
   logic [15:0] len_inc;
   logic        acc, pop, kw_hit;

   assign c       = req_tdata;
   assign acc     = req_tvalid && req_tready;
   assign pop     = rsp_tvalid && rsp_tready;
   assign len_inc = (len_ff == 16'hFFFF) ? len_ff : len_ff + 16'd1;
   assign sk      = char_kind(c);

   assign req_tready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_tready);
   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tuser  = slot_ff[0].kind;
   assign rsp_tdata  = {5'd0, slot_ff[0].err, slot_ff[0].len, slot_ff[0].start};
   assign rsp_tlast  = slot_ff[0].last;

   // keyword match over the buffered head of the identifier
   always_comb begin
      kw_kind = KIND_IDENT;
      kw_hit  = 1'b0;
      for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
         kw_hit = (len_ff == 16'(KW_LEN[i]));
         for (int j = 0; j < 6; j++) begin
            if (j < int'(KW_LEN[i]) && j < KEYWORD_MAX_LEN &&
                kb_ff[j] != KW_TEXT[i][8*j +: 8]) begin
               kw_hit = 1'b0;
            end
         end
         if (kw_hit) begin
            kw_kind = KW_KIND[i];
         end
      end
   end

   always_comb begin
      ident_res = '{valid: 1'b1, kind: kw_kind, start: tstart_ff, len: len_ff,
                    err: ERR_NONE, last: 1'b0};
   end

   // next state and results for the accepted request
   always_comb begin
      mode_in   = mode_ff;
      off_in    = off_ff;
      tstart_in = tstart_ff;
      pend_in   = pend_ff;
      kb_in     = kb_ff;
      len_in    = len_ff;
      dash_in   = dash_ff;
      halt_in   = halt_ff;
      r0        = '0;
      r1        = '0;
      take_sfi  = 1'b0;
      sfi_res   = '0;

      if (req_tlast) begin
         if (!halt_ff) begin
            unique case (mode_ff) inside
               MODE_IDENT: r0 = ident_res;
               MODE_CONST: r0 = '{1'b1, KIND_CONST, tstart_ff, len_ff, ERR_NONE, 1'b0};
               MODE_OP: begin
                  if (pend_ff == CH_AMP) begin
                     r0 = '{1'b1, KIND_END, tstart_ff, 16'd0, ERR_AMP, 1'b0};
                  end else if (pend_ff == CH_BAR) begin
                     r0 = '{1'b1, KIND_END, tstart_ff, 16'd0, ERR_BAR, 1'b0};
                  end else begin
                     r0 = '{1'b1, single_op_kind(pend_ff), tstart_ff, 16'd1,
                            ERR_NONE, 1'b0};
                  end
               end
               MODE_BLOCK:  r0 = '{1'b1, KIND_END, tstart_ff, 16'd0, ERR_COMMENT, 1'b0};
               MODE_STRING: r0 = '{1'b1, KIND_END, tstart_ff, 16'd0, ERR_STRING, 1'b0};
               MODE_CH1, MODE_CH2:
                  r0 = '{1'b1, KIND_END, tstart_ff, 16'd0, ERR_CHARLIT, 1'b0};
               default: r0 = '0;
            endcase
            // end token unless the flush itself was an error
            if (!(r0.valid && r0.err != ERR_NONE)) begin
               if (r0.valid) begin
                  r1 = '{1'b1, KIND_END, off_ff, 16'd0, ERR_NONE, 1'b0};
               end else begin
                  r0 = '{1'b1, KIND_END, off_ff, 16'd0, ERR_NONE, 1'b0};
               end
            end
         end
         mode_in   = MODE_IDLE;
         off_in    = '0;
         tstart_in = '0;
         pend_in   = '0;
         for (int j = 0; j < KEYWORD_MAX_LEN; j++) kb_in[j] = '0;
         len_in    = '0;
         dash_in   = 1'b0;
         halt_in   = 1'b0;
      end else begin
         if (!halt_ff) begin
            unique case (mode_ff)
               MODE_LINE: begin
                  if (c == CH_NL) mode_in = MODE_IDLE;
               end
               MODE_BLOCK: begin
                  if (dash_ff && c == CH_BANG) begin
                     dash_in = 1'b0;
                     mode_in = MODE_IDLE;
                  end else begin
                     dash_in = (c == CH_MINUS);
                  end
               end
               MODE_IDENT: begin
                  if (is_alpha(c) || is_digit(c)) begin
                     for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                        if (len_ff == 16'(j)) kb_in[j] = c;
                     end
                     len_in = len_inc;
                  end else begin
                     r0       = ident_res;
                     mode_in  = MODE_IDLE;
                     take_sfi = 1'b1;
                  end
               end
               MODE_CONST: begin
                  if (is_digit(c)) begin
                     len_in = len_inc;
                  end else begin
                     r0       = '{1'b1, KIND_CONST, tstart_ff, len_ff, ERR_NONE, 1'b0};
                     mode_in  = MODE_IDLE;
                     take_sfi = 1'b1;
                  end
               end
               MODE_STRING: begin
                  len_in = len_inc;
                  if (c == CH_DQUOTE) begin
                     r0      = '{1'b1, KIND_STRLIT, tstart_ff, len_inc, ERR_NONE, 1'b0};
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_CH1: begin
                  pend_in = c;
                  mode_in = MODE_CH2;
               end
               MODE_CH2: begin
                  mode_in = MODE_IDLE;
                  if (c == CH_SQUOTE) begin
                     r0 = '{1'b1, KIND_CHARLIT, tstart_ff, 16'd3, ERR_NONE, 1'b0};
                  end else begin
                     r0      = '{1'b1, KIND_END, tstart_ff, 16'd0, ERR_CHARLIT, 1'b0};
                     halt_in = 1'b1;
                  end
               end
               MODE_OP: begin
                  mode_in = MODE_IDLE;
                  if (pend_ff == CH_AMP || pend_ff == CH_BAR) begin
                     if (c == pend_ff) begin
                        r0 = '{1'b1, (pend_ff == CH_AMP) ? KIND_AND : KIND_OR,
                               tstart_ff, 16'd2, ERR_NONE, 1'b0};
                     end else begin
                        r0 = '{1'b1, KIND_END, tstart_ff, 16'd0,
                               (pend_ff == CH_AMP) ? ERR_AMP : ERR_BAR, 1'b0};
                        halt_in = 1'b1;
                     end
                  end else if (pend_ff == CH_BANG && c == CH_BANG) begin
                     mode_in = MODE_LINE;
                  end else if (pend_ff == CH_BANG && c == CH_MINUS) begin
                     dash_in = 1'b0;
                     mode_in = MODE_BLOCK;
                  end else if (pend_ff == CH_PLUS && c == CH_PLUS) begin
                     r0 = '{1'b1, KIND_INC, tstart_ff, 16'd2, ERR_NONE, 1'b0};
                  end else if (pend_ff == CH_MINUS && c == CH_MINUS) begin
                     r0 = '{1'b1, KIND_DEC, tstart_ff, 16'd2, ERR_NONE, 1'b0};
                  end else if (c == CH_EQ && pend_ff == CH_LT) begin
                     r0 = '{1'b1, KIND_LE, tstart_ff, 16'd2, ERR_NONE, 1'b0};
                  end else if (c == CH_EQ && pend_ff == CH_GT) begin
                     r0 = '{1'b1, KIND_GE, tstart_ff, 16'd2, ERR_NONE, 1'b0};
                  end else if (c == CH_EQ && pend_ff == CH_EQ) begin
                     r0 = '{1'b1, KIND_EQ, tstart_ff, 16'd2, ERR_NONE, 1'b0};
                  end else if (c == CH_EQ && pend_ff == CH_BANG) begin
                     r0 = '{1'b1, KIND_NE, tstart_ff, 16'd2, ERR_NONE, 1'b0};
                  end else begin
                     r0 = '{1'b1, single_op_kind(pend_ff), tstart_ff, 16'd1,
                            ERR_NONE, 1'b0};
                     take_sfi = 1'b1;
                  end
               end
               default: begin
                  mode_in  = MODE_IDLE;
                  take_sfi = 1'b1;
               end
            endcase

            // byte seen from the idle state
            if (take_sfi) begin
               if (sk != KIND_END) begin
                  sfi_res = '{1'b1, sk, off_ff, 16'd1, ERR_NONE, 1'b0};
               end else if (!(c == CH_SPACE || (c >= 8'd9 && c <= 8'd13))) begin
                  tstart_in = off_ff;
                  if (c == CH_PLUS || c == CH_MINUS || c == CH_LT || c == CH_GT ||
                      c == CH_EQ || c == CH_BANG || c == CH_AMP || c == CH_BAR) begin
                     pend_in = c;
                     mode_in = MODE_OP;
                  end else if (c == CH_DQUOTE) begin
                     len_in  = 16'd1;
                     mode_in = MODE_STRING;
                  end else if (c == CH_SQUOTE) begin
                     mode_in = MODE_CH1;
                  end else if (is_digit(c)) begin
                     len_in  = 16'd1;
                     mode_in = MODE_CONST;
                  end else if (is_alpha(c)) begin
                     for (int j = 0; j < KEYWORD_MAX_LEN; j++) kb_in[j] = '0;
                     kb_in[0] = c;
                     len_in   = 16'd1;
                     mode_in  = MODE_IDENT;
                  end else begin
                     sfi_res = '{1'b1, KIND_END, off_ff, 16'd0, ERR_BADCHAR, 1'b0};
                     halt_in = 1'b1;
                     mode_in = MODE_IDLE;
                  end
               end
               if (r0.valid) r1 = sfi_res;
               else          r0 = sfi_res;
            end
         end
         if (off_ff < OFFSET_CAP) off_in = off_ff + 16'd1;
      end

      r0.last = r0.valid && !r1.valid;
      r1.last = r1.valid;
   end

   // result buffer: accept only when it drains to empty this cycle
   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         cnt_in     = cnt_ff - 2'd1;
      end
      if (acc) begin
         slot_in[0] = r0;
         slot_in[1] = r1;
         cnt_in     = {1'b0, r0.valid} + {1'b0, r1.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         off_ff    <= '0;
         tstart_ff <= '0;
         pend_ff   <= '0;
         for (int j = 0; j < KEYWORD_MAX_LEN; j++) kb_ff[j] <= '0;
         len_ff    <= '0;
         dash_ff   <= 1'b0;
         halt_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (acc) begin
            mode_ff   <= mode_in;
            off_ff    <= off_in;
            tstart_ff <= tstart_in;
            pend_ff   <= pend_in;
            kb_ff     <= kb_in;
            len_ff    <= len_in;
            dash_ff   <= dash_in;
            halt_ff   <= halt_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("result buffer overfilled");

   a_head_not_last: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !slot_ff[0].last && slot_ff[1].last)
      else $error("two buffered tokens with wrong last flags");

   a_halt_idle: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> mode_ff == MODE_IDLE) else $error("halted while scanning");

   a_eos_restart: assert property (@(posedge clock) disable iff (reset)
      acc && req_tlast |=> !halt_ff && mode_ff == MODE_IDLE && off_ff == 16'd0)
      else $error("end of source did not restart scanner");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && slot_ff[0].err != ERR_NONE |-> slot_ff[0].last)
      else $error("error token not last of its run");

endmodule

[sim/source_tokenizer_tb.sv]
// source_tokenizer_tb: self-checking testbench for the streaming source tokenizer.
// Depends on stok_pkg and source_tokenizer; a scoreboard class predicts and checks tokens.
module source_tokenizer_tb;
   import stok_pkg::*;

   typedef struct {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [2:0]  err;
      logic        last;
   } token_type;

   // token predictor and store of pending tokens
   class token_scoreboard;
      token_type   pending_tokens[$];
      int          mismatches;
      int          tokens_seen;
      mode_type    mode;
      logic [15:0] offset;
      logic [15:0] tok_start;
      logic [7:0]  held_char;
      logic [7:0]  kw_buf [6];
      logic [15:0] run_len;
      logic        dash;
      logic        halted;
      token_type   batch[$];

      function new();
         mismatches = 0;
         tokens_seen = 0;
         clear_state();
      endfunction

      function void clear_state();
         mode = MODE_IDLE;
         offset = '0;
         tok_start = '0;
         held_char = '0;
         foreach (kw_buf[i]) kw_buf[i] = '0;
         run_len = '0;
         dash = 1'b0;
         halted = 1'b0;
      endfunction

      function void put(logic [5:0] k, logic [15:0] s, logic [15:0] l, logic [2:0] e);
         token_type t;
         t.kind = k;
         t.start = s;
         t.len = l;
         t.err = e;
         t.last = 1'b0;
         if (batch.size() < 2) batch = {batch, t};
      endfunction

      function void fail(logic [2:0] code, logic [15:0] s);
         put(KIND_END, s, 16'd0, code);
         halted = 1'b1;
         mode = MODE_IDLE;
      endfunction

      function bit alpha(logic [7:0] c);
         return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
      endfunction

      function bit digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function void flush_ident();
         logic [5:0] k;
         bit hit;
         k = KIND_IDENT;
         for (int i = 0; i < KEYWORD_COUNT; i++) begin
            if (run_len == 16'(KW_LEN[i]) && k == KIND_IDENT) begin
               hit = 1;
               for (int j = 0; j < KW_LEN[i]; j++)
                  if (kw_buf[j] != KW_TEXT[i][8*j +: 8]) hit = 0;
               if (hit) k = KW_KIND[i];
            end
         end
         put(k, tok_start, run_len, ERR_NONE);
         mode = MODE_IDLE;
      endfunction

      function logic [5:0] lone_op(logic [7:0] p);
         case (p)
            CH_PLUS:  return KIND_PLUS;
            CH_MINUS: return KIND_MINUS;
            CH_LT:    return KIND_LT;
            CH_GT:    return KIND_GT;
            CH_EQ:    return KIND_ASSIGN;
            default:  return KIND_NOT;
         endcase
      endfunction

      function void begin_token(logic [7:0] c);
         logic [5:0] k;
         case (c)
            "(": k = KIND_LPAREN;
            ")": k = KIND_RPAREN;
            "{": k = KIND_LBRACE;
            "}": k = KIND_RBRACE;
            "*": k = KIND_STAR;
            "/": k = KIND_SLASH;
            "%": k = KIND_PERCENT;
            ",": k = KIND_COMMA;
            ";": k = KIND_SEMI;
            "0": k = KIND_CONST;
            default: k = KIND_END;
         endcase
         if (k != KIND_END) begin
            put(k, offset, 16'd1, ERR_NONE);
            return;
         end
         if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13)) return;
         tok_start = offset;
         if (c inside {CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_EQ, CH_BANG, CH_AMP, CH_BAR}) begin
            held_char = c;
            mode = MODE_OP;
         end else if (c == CH_DQUOTE) begin
            run_len = 16'd1;
            mode = MODE_STRING;
         end else if (c == CH_SQUOTE) begin
            mode = MODE_CH1;
         end else if (digit(c)) begin
            run_len = 16'd1;
            mode = MODE_CONST;
         end else if (alpha(c)) begin
            foreach (kw_buf[i]) kw_buf[i] = '0;
            kw_buf[0] = c;
            run_len = 16'd1;
            mode = MODE_IDENT;
         end else begin
            fail(ERR_BADCHAR, offset);
         end
      endfunction

      function void op_next(logic [7:0] c);
         logic [7:0] p;
         logic [5:0] k;
         p = held_char;
         k = KIND_END;
         if (p == CH_AMP || p == CH_BAR) begin
            if (c == p) put(p == CH_AMP ? KIND_AND : KIND_OR, tok_start, 16'd2, ERR_NONE);
            else fail(p == CH_AMP ? ERR_AMP : ERR_BAR, tok_start);
            mode = MODE_IDLE;
            return;
         end
         if (p == CH_BANG && c == CH_BANG) begin
            mode = MODE_LINE;
            return;
         end
         if (p == CH_BANG && c == CH_MINUS) begin
            dash = 1'b0;
            mode = MODE_BLOCK;
            return;
         end
         if (p == CH_PLUS && c == CH_PLUS) k = KIND_INC;
         else if (p == CH_MINUS && c == CH_MINUS) k = KIND_DEC;
         else if (c == CH_EQ) begin
            if (p == CH_LT) k = KIND_LE;
            else if (p == CH_GT) k = KIND_GE;
            else if (p == CH_EQ) k = KIND_EQ;
            else if (p == CH_BANG) k = KIND_NE;
         end
         mode = MODE_IDLE;
         if (k != KIND_END) begin
            put(k, tok_start, 16'd2, ERR_NONE);
            return;
         end
         put(lone_op(p), tok_start, 16'd1, ERR_NONE);
         begin_token(c);
      endfunction

      // note one accepted request and queue the tokens it should cause
      function void note_request(logic [7:0] c, logic eos);
         batch.delete();
         if (eos) begin
            if (!halted) begin
               case (mode) inside
                  MODE_IDENT: flush_ident();
                  MODE_CONST: put(KIND_CONST, tok_start, run_len, ERR_NONE);
                  MODE_OP:
                     if (held_char == CH_AMP) fail(ERR_AMP, tok_start);
                     else if (held_char == CH_BAR) fail(ERR_BAR, tok_start);
                     else put(lone_op(held_char), tok_start, 16'd1, ERR_NONE);
                  MODE_BLOCK: fail(ERR_COMMENT, tok_start);
                  MODE_STRING: fail(ERR_STRING, tok_start);
                  MODE_CH1, MODE_CH2: fail(ERR_CHARLIT, tok_start);
                  default: ;
               endcase
               if (!halted) put(KIND_END, offset, 16'd0, ERR_NONE);
            end
            clear_state();
         end else begin
            if (!halted) begin
               case (mode)
                  MODE_LINE: if (c == CH_NL) mode = MODE_IDLE;
                  MODE_BLOCK:
                     if (dash && c == CH_BANG) begin
                        dash = 1'b0;
                        mode = MODE_IDLE;
                     end else dash = (c == CH_MINUS);
                  MODE_IDENT:
                     if (alpha(c) || digit(c)) begin
                        if (run_len < 16'd6) kw_buf[run_len] = c;
                        if (run_len != 16'hFFFF) run_len++;
                     end else begin
                        flush_ident();
                        begin_token(c);
                     end
                  MODE_CONST:
                     if (digit(c)) begin
                        if (run_len != 16'hFFFF) run_len++;
                     end else begin
                        put(KIND_CONST, tok_start, run_len, ERR_NONE);
                        mode = MODE_IDLE;
                        begin_token(c);
                     end
                  MODE_STRING: begin
                     if (run_len != 16'hFFFF) run_len++;
                     if (c == CH_DQUOTE) begin
                        put(KIND_STRLIT, tok_start, run_len, ERR_NONE);
                        mode = MODE_IDLE;
                     end
                  end
                  MODE_CH1: begin
                     held_char = c;
                     mode = MODE_CH2;
                  end
                  MODE_CH2:
                     if (c == CH_SQUOTE) begin
                        put(KIND_CHARLIT, tok_start, 16'd3, ERR_NONE);
                        mode = MODE_IDLE;
                     end else fail(ERR_CHARLIT, tok_start);
                  MODE_OP: op_next(c);
                  default: begin
                     mode = MODE_IDLE;
                     begin_token(c);
                  end
               endcase
            end
            if (offset != 16'hFFFF) offset++;
         end
         if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
         foreach (batch[i]) pending_tokens = {pending_tokens, batch[i]};
      endfunction

      // compare one accepted token against the oldest pending one
      function void check_token(token_type got);
         token_type exp;
         tokens_seen++;
         if (pending_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected token kind=%0d start=%0d len=%0d err=%0d",
                        got.kind, got.start, got.len, got.err);
            return;
         end
         exp = pending_tokens.pop_front();
         if (got.kind !== exp.kind || got.start !== exp.start || got.len !== exp.len ||
             got.err !== exp.err || got.last !== exp.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: exp k=%0d s=%0d l=%0d e=%0d t=%0d got k=%0d s=%0d l=%0d e=%0d t=%0d",
                        exp.kind, exp.start, exp.len, exp.err, exp.last,
                        got.kind, got.start, got.len, got.err, got.last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [5:0]  rsp_tuser;
   logic        rsp_tlast;

   token_scoreboard sb;
   logic [8:0]  src_text[$];   // {end_of_source, byte}
   int          requests_sent;
   int          sources_sent;
   bit          long_hold;

   source_tokenizer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Simulation FAILED");
      $finish;
   end

   // source building helpers
   task automatic add_byte(logic [8:0] b);
      src_text = {src_text, b};
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte({1'b0, s[i]});
   endtask

   task automatic add_end();
      add_byte(9'h100);
   endtask

   function automatic string pick(string opts[]);
      return opts[$urandom_range(opts.size()-1)];
   endfunction

   // a random well-formed fragment of the language
   function automatic string rand_fragment();
      string s;
      int n;
      case ($urandom_range(11))
         0: s = pick('{"char", "else", "for", "hop", "if", "int", "string", "while",
                      "iff", "whilex", "strings", "in", "_x9", "Zz"});
         1: begin
            n = $urandom_range(1, 9);
            s = "";
            for (int i = 0; i < n; i++) s = {s, string'(byte'("a" + $urandom_range(25)))};
         end
         2: begin
            n = $urandom_range(1, 5);
            s = string'(byte'("1" + $urandom_range(8)));
            for (int i = 1; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(9)))};
         end
         3: s = pick('{"0", "00", "07"});
         4: s = pick('{"++", "+", "--", "-", "<=", "<", ">=", ">", "==", "=", "!=", "!",
                      "&&", "||", "+=", "-+", "=<"});
         5: s = pick('{"(", ")", "{", "}", "*", "/", "%", ",", ";"});
         6: s = pick('{"\"hi\"", "\"\"", "\"a b !! c\"", "\"x'y\""});
         7: begin
            s = "'";
            s = {s, string'(byte'($urandom_range(255))), "'"};
         end
         8: s = pick('{"!! note\n", "!-- x -!", "!- a-b -!", "!---!", "!!\n"});
         9: s = pick('{" ", "\t", "\n", "\r", "  "});
         10: s = pick('{"a+b", "x=0;", "if(a<=b)", "f(1,2)", "s=\"q\";"});
         default: s = " ";
      endcase
      return s;
   endfunction

   task automatic build_stimulus();
      int total;
      string s;
      // directed: every kind, keywords, literals and each corner case
      add_text("(){}*/%,;++ + -- - <= < >= > == = != ! && || ;"); add_end();
      add_text("char else for hop if int string while _Id9 whilez"); add_end();
      add_text("\"s\" 'c' 0 007 123 x!!c\ny !-a!-!b-!z"); add_end();
      add_text("&x"); add_end();
      add_text("|"); add_end();
      add_text("!- open"); add_end();
      add_text("\"open"); add_end();
      add_text("'ab'"); add_end();
      add_text("'"); add_end();
      add_byte({1'b0, 8'hFF}); add_byte({1'b0, 8'h00}); add_end();
      add_text("abc"); add_end();
      add_text("+"); add_end();
      add_end();
      total = src_text.size();
      // random: mostly well-formed fragments, some raw noise
      while (src_text.size() < total + 1250) begin
         n_frag: for (int f = $urandom_range(1, 12); f > 0; f--) begin
            if ($urandom_range(19) == 0) begin
               add_byte({1'b0, 8'($urandom_range(255))});
            end else begin
               s = rand_fragment();
               add_text(s);
            end
         end
         if ($urandom_range(4) == 0) add_byte({1'b1, 8'($urandom_range(255))});
         else add_end();
      end
      // one long identifier to push lengths past the keyword buffer
      for (int i = 0; i < 300; i++) add_byte({1'b0, 8'h61});
      add_end();
   endtask

   task automatic drive_requests();
      int burst;
      logic [8:0] item;
      for (int i = 0; i < src_text.size(); i++) begin
         item = src_text[i];
         // pause until every token has drained, once, mid-run
         if (i == src_text.size() / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (sb.pending_tokens.size() != 0) @(posedge clock);
         end
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(2) == 0 && i > 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         burst--;
         req_tvalid <= 1'b1;
         req_tdata  <= item[7:0];
         req_tlast  <= item[8];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sb.note_request(item[7:0], item[8]);
         requests_sent++;
         if (item[8]) sources_sent++;
      end
      req_tvalid <= 1'b0;
   endtask

   // receiver: own stall pattern plus one long hold-off
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) rsp_tready <= 1'b0;
         else case ((requests_sent / 97) % 3)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(3) != 0);
            default: rsp_tready <= ($urandom_range(1) != 0);
         endcase
      end
   end

   initial begin
      long_hold = 1'b0;
      wait (requests_sent > 400);
      long_hold = 1'b1;
      repeat (200) @(posedge clock);
      long_hold = 1'b0;
   end

   // token monitor
   always @(posedge clock) begin
      token_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind  = rsp_tuser;
         got.start = rsp_tdata[15:0];
         got.len   = rsp_tdata[31:16];
         got.err   = rsp_tdata[34:32];
         got.last  = rsp_tlast;
         sb.check_token(got);
      end
   end

   initial begin
      int guard;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      requests_sent = 0;
      sources_sent = 0;
      build_stimulus();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      drive_requests();
      guard = 0;
      while (sb.pending_tokens.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (sb.pending_tokens.size() != 0) begin
         sb.mismatches++;
         $display("ERROR: %0d tokens never arrived", sb.pending_tokens.size());
      end
      $display("Covered %0d requests in %0d sources, %0d tokens checked, %0d mismatches",
               requests_sent, sources_sent, sb.tokens_seen, sb.mismatches);
      if (sb.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
